@@ rtl/kbed_pkg.sv @@
`timescale 1ns / 1ps

package kbed_pkg;

    // width and reset value of the hold threshold register
    localparam int          HOLD_TICKS_W     = 24;
    localparam logic [23:0] HOLD_TICKS_RESET = 24'd2000;

    // event codes
    localparam logic [1:0] EV_CW     = 2'd0;
    localparam logic [1:0] EV_CCW    = 2'd1;
    localparam logic [1:0] EV_PUSHED = 2'd2;
    localparam logic [1:0] EV_HELD   = 2'd3;

    // knob codes, {!a, !b}
    localparam logic [1:0] KNOB_CODE_NONE = 2'b00;
    localparam logic [1:0] KNOB_CODE_B    = 2'b01;
    localparam logic [1:0] KNOB_CODE_A    = 2'b10;
    localparam logic [1:0] KNOB_CODE_BOTH = 2'b11;

    // one sample tick
    typedef struct packed {
        logic knob_a;
        logic knob_b;
        logic button_level;
    } t_in_item;

    // one decoded event
    typedef struct packed {
        logic [1:0] event_code;
        logic       last_event;
    } t_out_item;

    // events of one tick as they travel through the queue
    typedef struct packed {
        logic       two;
        logic [1:0] ev0;
        logic [1:0] ev1;
    } t_bundle;

endpackage

@@ rtl/kbed_front.sv @@
`timescale 1ns / 1ps

module kbed_front #(
    parameter int HOLD_COUNT_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kbed_pkg::HOLD_TICKS_W-1:0]   i_cfg_data,
    input  logic                                i_accept,
    input  kbed_pkg::t_in_item                  i_item,
    output logic                                o_push,
    output kbed_pkg::t_bundle                   o_bundle
);

    localparam int CMP_W = (HOLD_COUNT_WIDTH > kbed_pkg::HOLD_TICKS_W) ?
                           HOLD_COUNT_WIDTH : kbed_pkg::HOLD_TICKS_W;
    localparam logic [HOLD_COUNT_WIDTH-1:0] CNT_MAX = {HOLD_COUNT_WIDTH{1'b1}};

    localparam logic [1:0] KP_IDLE  = 2'd0;
    localparam logic [1:0] KP_FIRST = 2'd1;
    localparam logic [1:0] KP_BOTH  = 2'd2;

    localparam logic [1:0] BP_IDLE  = 2'd0;
    localparam logic [1:0] BP_COUNT = 2'd1;
    localparam logic [1:0] BP_HELD  = 2'd2;

    logic [kbed_pkg::HOLD_TICKS_W-1:0] r_hold_ticks;
    logic [1:0]                        r_knob_phase, n_knob_phase;
    logic [1:0]                        r_first_code, n_first_code;
    logic [1:0]                        r_button_phase, n_button_phase;
    logic [HOLD_COUNT_WIDTH-1:0]       r_held_count, n_held_count;

    logic [1:0]                  code;
    logic                        pressed;
    logic                        knob_ev;
    logic [1:0]                  knob_code;
    logic                        btn_ev;
    logic [1:0]                  btn_code;
    logic [HOLD_COUNT_WIDTH-1:0] cnt_inc;

    assign code    = {~i_item.knob_a, ~i_item.knob_b};
    assign pressed = ~i_item.button_level;
    assign cnt_inc = (r_held_count != CNT_MAX) ?
                     r_held_count + HOLD_COUNT_WIDTH'(1) : r_held_count;

    // knob step decoding
    always_comb begin
        n_knob_phase = r_knob_phase;
        n_first_code = r_first_code;
        knob_ev      = 1'b0;
        knob_code    = kbed_pkg::EV_CCW;
        unique case (r_knob_phase)
            KP_FIRST: begin
                if (code != r_first_code) begin
                    n_knob_phase = (code == kbed_pkg::KNOB_CODE_BOTH) ? KP_BOTH : KP_IDLE;
                end
            end
            KP_BOTH: begin
                if (code != kbed_pkg::KNOB_CODE_BOTH) begin
                    knob_ev = 1'b1;
                    if (code == kbed_pkg::KNOB_CODE_B &&
                        r_first_code == kbed_pkg::KNOB_CODE_A) begin
                        knob_code = kbed_pkg::EV_CW;
                    end
                    n_knob_phase = KP_IDLE;
                end
            end
            default: begin
                if (code != kbed_pkg::KNOB_CODE_NONE) begin
                    n_first_code = code;
                    n_knob_phase = KP_FIRST;
                end else begin
                    n_knob_phase = KP_IDLE;
                end
            end
        endcase
    end

    // button press and hold decoding
    always_comb begin
        n_button_phase = r_button_phase;
        n_held_count   = r_held_count;
        btn_ev         = 1'b0;
        btn_code       = kbed_pkg::EV_PUSHED;
        unique case (r_button_phase)
            BP_COUNT: begin
                if (pressed) begin
                    n_held_count = cnt_inc;
                    if (CMP_W'(cnt_inc) >= CMP_W'(r_hold_ticks)) begin
                        btn_ev         = 1'b1;
                        btn_code       = kbed_pkg::EV_HELD;
                        n_button_phase = BP_HELD;
                    end
                end else begin
                    n_button_phase = BP_IDLE;
                end
            end
            BP_HELD: begin
                if (!pressed) begin
                    n_button_phase = BP_IDLE;
                end
            end
            default: begin
                if (pressed) begin
                    btn_ev         = 1'b1;
                    n_held_count   = '0;
                    n_button_phase = BP_COUNT;
                end else begin
                    n_button_phase = BP_IDLE;
                end
            end
        endcase
    end

    // rotation event first, button event second
    always_comb begin
        o_push       = i_accept & (knob_ev | btn_ev);
        o_bundle.two = knob_ev & btn_ev;
        o_bundle.ev0 = knob_ev ? knob_code : btn_code;
        o_bundle.ev1 = btn_code;
    end

    // decoder state and threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks   <= kbed_pkg::HOLD_TICKS_RESET;
            r_knob_phase   <= KP_IDLE;
            r_first_code   <= kbed_pkg::KNOB_CODE_NONE;
            r_button_phase <= BP_IDLE;
            r_held_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_hold_ticks <= i_cfg_data;
            end
            if (i_accept) begin
                r_knob_phase   <= n_knob_phase;
                r_first_code   <= n_first_code;
                r_button_phase <= n_button_phase;
                r_held_count   <= n_held_count;
            end
        end
    end

    // two events in one tick are always a rotation then a button event
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_bundle.two |->
            (o_bundle.ev0 == kbed_pkg::EV_CW || o_bundle.ev0 == kbed_pkg::EV_CCW) &&
            (o_bundle.ev1 == kbed_pkg::EV_PUSHED || o_bundle.ev1 == kbed_pkg::EV_HELD))
        else $error("front: bad event pair");

    // a held event moves the button into the wait for release
    a_held_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && btn_ev && btn_code == kbed_pkg::EV_HELD |=> r_button_phase == BP_HELD)
        else $error("front: held without phase change");

    // a press always restarts the hold count
    a_press_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && btn_ev && btn_code == kbed_pkg::EV_PUSHED |=> r_held_count == '0)
        else $error("front: hold count not cleared on press");

endmodule

@@ rtl/kbed_queue.sv @@
`timescale 1ns / 1ps

module kbed_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kbed_pkg::t_bundle i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output kbed_pkg::t_bundle o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    kbed_pkg::t_bundle r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue: pop while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue: fill count out of range");

endmodule

@@ rtl/kbed_back.sv @@
`timescale 1ns / 1ps

module kbed_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  kbed_pkg::t_bundle   i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output kbed_pkg::t_out_item o_data
);

    logic                r_valid, n_valid;
    logic                r_sub, n_sub;
    kbed_pkg::t_out_item r_data, n_data;
    logic                load;

    assign load    = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // split the head entry into single events
    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        n_data  = r_data;
        o_pop   = 1'b0;
        if (load) begin
            if (i_empty) begin
                n_valid = 1'b0;
            end else begin
                n_valid = 1'b1;
                if (i_head.two && !r_sub) begin
                    n_data.event_code = i_head.ev0;
                    n_data.last_event = 1'b0;
                    n_sub             = 1'b1;
                end else begin
                    n_data.event_code = r_sub ? i_head.ev1 : i_head.ev0;
                    n_data.last_event = 1'b1;
                    n_sub             = 1'b0;
                    o_pop             = 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // the first half of a pair is on show while its entry stays queued
    a_sub_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> r_valid && !i_empty && !r_data.last_event)
        else $error("back: pair state without shown event");

    // once the first of a pair is taken the second follows, marked last
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub && i_ready |=> r_valid && r_data.last_event)
        else $error("back: second event of pair missing");

    // an entry leaves the queue only with its final event
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid && r_data.last_event)
        else $error("back: entry popped without final event");

endmodule

@@ rtl/knob_and_button_event_decoder_core.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// sample    in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
// event     out        o_out_valid / i_out_ready  o_out_data (t_out_item)
// config    in         i_cfg_we                   i_cfg_data (hold_ticks, 24 bits)
//
// one sample transaction is taken per cycle while the queue is not full; its
// events (0 to 2) reach the event port through a QUEUE_DEPTH entry queue
// and an output register, at one event per cycle while i_out_ready is high
// o_in_ready drops only when the queue is full; a tick with two events holds
// its queue entry until its second event is loaded into the output register
// reset is synchronous and active low

module knob_and_button_event_decoder_core #(
    parameter int HOLD_COUNT_WIDTH = 24,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  kbed_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output kbed_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [kbed_pkg::HOLD_TICKS_W-1:0] i_cfg_data
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    kbed_pkg::t_bundle bundle;
    kbed_pkg::t_bundle head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    // sample decode
    kbed_front #(
        .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .o_push     (push),
        .o_bundle   (bundle)
    );

    // event queue
    kbed_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (bundle),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // event output
    kbed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
